// ----- rtl/strm_pkg.sv -----
package strm_pkg;

   // Port field widths
   localparam int IDX_W  = 10;
   localparam int VAL_W  = 32;
   localparam int SIZE_W = 11;
   localparam int LVL_W  = 5;   // holds any table level up to 32 levels

   localparam logic [SIZE_W-1:0] SIZE_RESET = 11'd1024;

   localparam int DEF_MAX_ELEMENTS = 1024;
   localparam int DEF_TABLE_LEVELS = 11;
   localparam int DEF_VALUE_BITS   = 32;

   localparam int QUEUE_DEPTH = 2;

   // Command kinds handed from the front end to the back end
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_QUERY = 2'd1;
   localparam logic [1:0] CMD_ERROR = 2'd2;

   typedef struct packed {
      logic [1:0]       kind;
      logic [IDX_W-1:0] index;
      logic [VAL_W-1:0] value;
      logic [IDX_W-1:0] first;
      logic [IDX_W-1:0] second;
      logic [LVL_W-1:0] level;
   } cmd_type;

endpackage

// ----- rtl/strm_ram.sv -----
module strm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// ----- rtl/strm_front.sv -----
module strm_front #(
   parameter int MAX_ELEMENTS = strm_pkg::DEF_MAX_ELEMENTS,
   parameter int TABLE_LEVELS = strm_pkg::DEF_TABLE_LEVELS
) (
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic                                 req_mode,
   input  logic [strm_pkg::IDX_W-1:0]           req_write_index,
   input  logic signed [strm_pkg::VAL_W-1:0]    req_write_value,
   input  logic [strm_pkg::IDX_W-1:0]           req_range_start,
   input  logic [strm_pkg::IDX_W-1:0]           req_range_end,
   input  logic [$clog2(MAX_ELEMENTS+1)-1:0]    used_size,
   input  logic                                 can_accept,
   output logic                                 push,
   output strm_pkg::cmd_type                    cmd
);

   logic [strm_pkg::SIZE_W-1:0] len;
   logic [strm_pkg::LVL_W-1:0]  k;
   logic                        bad_range;
   logic                        wr_drop;

   assign req_ready = can_accept;

   always_comb begin
      len = strm_pkg::SIZE_W'(req_range_end) - strm_pkg::SIZE_W'(req_range_start)
            + strm_pkg::SIZE_W'(1);
      k = '0;
      for (int j = 1; j < TABLE_LEVELS; j++) begin
         if (int'(len) >= (1 << j)) begin
            k = strm_pkg::LVL_W'(j);
         end
      end
      bad_range = (req_range_start > req_range_end) ||
                  (int'(req_range_end) >= int'(used_size));
      wr_drop   = int'(req_write_index) >= int'(used_size);

      cmd.index  = req_write_index;
      cmd.value  = req_write_value;
      cmd.first  = req_range_start;
      cmd.second = strm_pkg::IDX_W'(strm_pkg::SIZE_W'(req_range_end) + strm_pkg::SIZE_W'(1)
                   - (strm_pkg::SIZE_W'(1) << k));
      cmd.level  = k;
      if (!req_mode) begin
         cmd.kind = strm_pkg::CMD_WRITE;
      end else if (bad_range) begin
         cmd.kind = strm_pkg::CMD_ERROR;
      end else begin
         cmd.kind = strm_pkg::CMD_QUERY;
      end
   end

   // out-of-range writes are dropped here
   assign push = req_valid && can_accept && !(!req_mode && wr_drop);

endmodule

// ----- rtl/strm_queue.sv -----
module strm_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  strm_pkg::cmd_type push_cmd,
   output logic              full,
   output logic              head_valid,
   output strm_pkg::cmd_type head_cmd,
   input  logic              pop
);

   localparam int PW = $clog2(strm_pkg::QUEUE_DEPTH);

   strm_pkg::cmd_type ent_ff [strm_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [PW:0]   count_ff, count_in;

   assign full       = count_ff == (PW+1)'(strm_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_cmd   = ent_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         ent_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ----- rtl/strm_back.sv -----
module strm_back #(
   parameter int MAX_ELEMENTS = strm_pkg::DEF_MAX_ELEMENTS,
   parameter int TABLE_LEVELS = strm_pkg::DEF_TABLE_LEVELS,
   parameter int VALUE_BITS   = strm_pkg::DEF_VALUE_BITS
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [$clog2(MAX_ELEMENTS+1)-1:0] used_size,
   input  logic                              cfg_write,
   input  logic                              cmd_valid,
   input  strm_pkg::cmd_type                 cmd,
   output logic                              cmd_pop,
   output logic                              clearing,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [strm_pkg::IDX_W-1:0]        rsp_min_position,
   output logic                              rsp_range_error
);

   localparam int AW     = $clog2(MAX_ELEMENTS);
   localparam int NW     = $clog2(MAX_ELEMENTS+1);
   localparam int LW     = $clog2(TABLE_LEVELS);
   localparam int SW     = ((NW > TABLE_LEVELS) ? NW : TABLE_LEVELS) + 1;
   localparam int TDEPTH = TABLE_LEVELS * (1 << AW);

   localparam logic [2:0] S_CLEAR  = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_BUILD  = 3'd2;
   localparam logic [2:0] S_QISSUE = 3'd3;
   localparam logic [2:0] S_QWAIT  = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   logic [LW-1:0] lvl_ff, lvl_in;
   logic [AW-1:0] i_ff, i_in;
   logic          stale_ff, stale_in;

   logic          p1_vld_ff, p1_vld_in;
   logic          p1_qry_ff, p1_qry_in;
   logic          p1_byp_ff, p1_byp_in;
   logic [AW-1:0] p1_ia_ff, p1_ia_in;
   logic [AW-1:0] p1_ib_ff, p1_ib_in;
   logic [AW-1:0] p1_dst_ff, p1_dst_in;
   logic          p2_vld_ff, p2_vld_in;
   logic          p2_qry_ff, p2_qry_in;
   logic [AW-1:0] p2_a_ff, p2_a_in;
   logic [AW-1:0] p2_b_ff, p2_b_in;
   logic [AW-1:0] p2_dst_ff, p2_dst_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [strm_pkg::IDX_W-1:0] rsp_pos_ff, rsp_pos_in;
   logic                       rsp_err_ff, rsp_err_in;

   logic [SW-1:0] pw, half, pw_next;
   logic          issue_ok, next_ok, pipe_empty;
   logic [LW-1:0] lvl_prev;
   logic [AW-1:0] ib_build;

   logic [LW+AW-1:0]     tbl_raddr_a, tbl_raddr_b;
   logic [AW-1:0]        tbl_rd_a, tbl_rd_b;
   logic                 tbl_we;
   logic [AW-1:0]        a1, b1, pick2;
   logic [VALUE_BITS-1:0] val_rd_a, val_rd_b;
   logic                 val_we;
   logic [AW-1:0]        val_waddr;
   logic [VALUE_BITS-1:0] val_wdata;

   always_comb begin
      pw         = SW'(1) << lvl_ff;
      half       = pw >> 1;
      pw_next    = pw << 1;
      issue_ok   = (SW'(i_ff) + pw) <= SW'(used_size);
      next_ok    = ((int'(lvl_ff) + 1) < TABLE_LEVELS) && (pw_next <= SW'(used_size));
      pipe_empty = !p1_vld_ff && !p2_vld_ff;
      lvl_prev   = lvl_ff - LW'(1);
      ib_build   = AW'(SW'(i_ff) + half);
      a1         = p1_byp_ff ? p1_ia_ff : tbl_rd_a;
      b1         = p1_byp_ff ? p1_ib_ff : tbl_rd_b;
      // right candidate wins unless left is strictly smaller
      pick2      = ($signed(val_rd_a) < $signed(val_rd_b)) ? p2_a_ff : p2_b_ff;
      tbl_we     = p2_vld_ff && !p2_qry_ff;
   end

   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      lvl_in    = lvl_ff;
      i_in      = i_ff;
      stale_in  = stale_ff | cfg_write;

      p1_vld_in = 1'b0;
      p1_qry_in = 1'b0;
      p1_byp_in = 1'b0;
      p1_ia_in  = i_ff;
      p1_ib_in  = ib_build;
      p1_dst_in = i_ff;
      p2_vld_in = p1_vld_ff;
      p2_qry_in = p1_qry_ff;
      p2_a_in   = a1;
      p2_b_in   = b1;
      p2_dst_in = p1_dst_ff;

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pos_in   = rsp_pos_ff;
      rsp_err_in   = rsp_err_ff;

      cmd_pop     = 1'b0;
      val_we      = 1'b0;
      val_waddr   = clr_ff;
      val_wdata   = '0;
      tbl_raddr_a = {lvl_prev, i_ff};
      tbl_raddr_b = {lvl_prev, ib_build};

      unique case (state_ff)
         S_CLEAR: begin
            val_we = 1'b1;
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_ELEMENTS-1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (cmd_valid) begin
               case (cmd.kind)
                  strm_pkg::CMD_WRITE: begin
                     val_we    = 1'b1;
                     val_waddr = AW'(cmd.index);
                     val_wdata = VALUE_BITS'($signed(cmd.value));
                     stale_in  = 1'b1;
                     cmd_pop   = 1'b1;
                  end
                  strm_pkg::CMD_ERROR: begin
                     if (!rsp_valid_ff) begin
                        rsp_valid_in = 1'b1;
                        rsp_pos_in   = '0;
                        rsp_err_in   = 1'b1;
                        cmd_pop      = 1'b1;
                     end
                  end
                  strm_pkg::CMD_QUERY: begin
                     if (stale_ff) begin
                        state_in = S_BUILD;
                        lvl_in   = LW'(1);
                        i_in     = '0;
                     end else begin
                        state_in = S_QISSUE;
                     end
                  end
                  default: cmd_pop = 1'b1;
               endcase
            end
         end
         S_BUILD: begin
            if (issue_ok) begin
               p1_vld_in = 1'b1;
               p1_byp_in = lvl_ff == LW'(1);   // level zero entries are the index itself
               i_in      = i_ff + AW'(1);
            end else if (pipe_empty) begin
               if (next_ok) begin
                  lvl_in = lvl_ff + LW'(1);
                  i_in   = '0;
               end else begin
                  stale_in = 1'b0;
                  state_in = S_QISSUE;
               end
            end
         end
         S_QISSUE: begin
            tbl_raddr_a = {LW'(cmd.level), AW'(cmd.first)};
            tbl_raddr_b = {LW'(cmd.level), AW'(cmd.second)};
            if (!rsp_valid_ff) begin
               p1_vld_in = 1'b1;
               p1_qry_in = 1'b1;
               p1_byp_in = cmd.level == '0;
               p1_ia_in  = AW'(cmd.first);
               p1_ib_in  = AW'(cmd.second);
               state_in  = S_QWAIT;
            end
         end
         S_QWAIT: begin
            if (p2_vld_ff && p2_qry_ff) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = strm_pkg::IDX_W'(pick2);
               rsp_err_in   = 1'b0;
               cmd_pop      = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         lvl_ff       <= '0;
         i_ff         <= '0;
         stale_ff     <= 1'b1;
         p1_vld_ff    <= 1'b0;
         p2_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         lvl_ff       <= lvl_in;
         i_ff         <= i_in;
         stale_ff     <= stale_in;
         p1_vld_ff    <= p1_vld_in;
         p2_vld_ff    <= p2_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      p1_qry_ff  <= p1_qry_in;
      p1_byp_ff  <= p1_byp_in;
      p1_ia_ff   <= p1_ia_in;
      p1_ib_ff   <= p1_ib_in;
      p1_dst_ff  <= p1_dst_in;
      p2_qry_ff  <= p2_qry_in;
      p2_a_ff    <= p2_a_in;
      p2_b_ff    <= p2_b_in;
      p2_dst_ff  <= p2_dst_in;
      rsp_pos_ff <= rsp_pos_in;
      rsp_err_ff <= rsp_err_in;
   end

   strm_ram #(.WIDTH(AW), .DEPTH(TDEPTH)) u_table (
      .clock     (clock),
      .wr_en     (tbl_we),
      .wr_addr   ({lvl_ff, p2_dst_ff}),
      .wr_data   (pick2),
      .rd_addr_a (tbl_raddr_a),
      .rd_addr_b (tbl_raddr_b),
      .rd_data_a (tbl_rd_a),
      .rd_data_b (tbl_rd_b)
   );

   strm_ram #(.WIDTH(VALUE_BITS), .DEPTH(MAX_ELEMENTS)) u_values (
      .clock     (clock),
      .wr_en     (val_we),
      .wr_addr   (val_waddr),
      .wr_data   (val_wdata),
      .rd_addr_a (a1),
      .rd_addr_b (b1),
      .rd_data_a (val_rd_a),
      .rd_data_b (val_rd_b)
   );

   assign clearing         = state_ff == S_CLEAR;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_min_position = rsp_pos_ff;
   assign rsp_range_error  = rsp_err_ff;

endmodule

// ----- rtl/sparse_table_range_min.sv -----
// Range-minimum block over a sparse table of minimum positions.
// Request channel (req_*): mode 0 writes req_write_value at req_write_index,
// mode 1 asks for the greatest position of the minimum in
// [req_range_start, req_range_end]. Writes give no response; each query gives
// one response on rsp_* with rsp_range_error set (position 0) for a bad range.
// csr_* writes size_in_use (elements in use); it is always ready and may only
// be written while the block is idle.
// A query with a fresh table passes the queue, the issue state, the table
// read, the value read and the compare into the response register; a
// bad-range query is answered from the queue head without the table.
// Throughput: one write per cycle while the back end is idle; one query at a time.
// The first query after writes or a size change rebuilds the table first,
// one entry per cycle within a level (the pipe drains between levels),
// set by the single table write port.
// Reset: value store clears to zero in a pass over all MAX_ELEMENTS entries
// (1024 by default); req_ready stays low during that pass.
// A stalled rsp_ready holds the response; the 2-entry request queue keeps
// taking requests until it fills, then req_ready drops.
module sparse_table_range_min #(
   parameter int MAX_ELEMENTS = strm_pkg::DEF_MAX_ELEMENTS,
   parameter int TABLE_LEVELS = strm_pkg::DEF_TABLE_LEVELS,
   parameter int VALUE_BITS   = strm_pkg::DEF_VALUE_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic [strm_pkg::IDX_W-1:0]         req_write_index,
   input  logic signed [strm_pkg::VAL_W-1:0]  req_write_value,
   input  logic [strm_pkg::IDX_W-1:0]         req_range_start,
   input  logic [strm_pkg::IDX_W-1:0]         req_range_end,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [strm_pkg::IDX_W-1:0]         rsp_min_position,
   output logic                               rsp_range_error,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [strm_pkg::SIZE_W-1:0]        csr_size_in_use
);

   localparam int NW = $clog2(MAX_ELEMENTS+1);

   logic [strm_pkg::SIZE_W-1:0] size_ff, size_in;
   logic [NW-1:0]               used_size;
   logic                        cfg_write;
   logic                        q_full, q_push, q_pop, q_valid, clearing;
   strm_pkg::cmd_type           front_cmd, head_cmd;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;
   assign size_in   = cfg_write ? csr_size_in_use : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= strm_pkg::SIZE_RESET;
      end else begin
         size_ff <= size_in;
      end
   end

   // an oversized register value acts as the full array
   assign used_size = (int'(size_ff) > MAX_ELEMENTS) ? NW'(MAX_ELEMENTS) : NW'(size_ff);

   strm_front #(.MAX_ELEMENTS(MAX_ELEMENTS), .TABLE_LEVELS(TABLE_LEVELS)) u_front (
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_write_index (req_write_index),
      .req_write_value (req_write_value),
      .req_range_start (req_range_start),
      .req_range_end   (req_range_end),
      .used_size       (used_size),
      .can_accept      (!q_full && !clearing),
      .push            (q_push),
      .cmd             (front_cmd)
   );

   strm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_cmd   (front_cmd),
      .full       (q_full),
      .head_valid (q_valid),
      .head_cmd   (head_cmd),
      .pop        (q_pop)
   );

   strm_back #(
      .MAX_ELEMENTS (MAX_ELEMENTS),
      .TABLE_LEVELS (TABLE_LEVELS),
      .VALUE_BITS   (VALUE_BITS)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .used_size        (used_size),
      .cfg_write        (cfg_write),
      .cmd_valid        (q_valid),
      .cmd              (head_cmd),
      .cmd_pop          (q_pop),
      .clearing         (clearing),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_min_position (rsp_min_position),
      .rsp_range_error  (rsp_range_error)
   );

   // no requests taken during the clearing pass
   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !req_ready)
      else $error("request accepted during clear");

   // queue never pushed while full
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("queue overflow");

   // error responses carry position zero
   a_err_pos_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_range_error) |-> (rsp_min_position == '0))
      else $error("error response with nonzero position");

   // pops only from a non-empty queue
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");

endmodule

// ----- dv/tb_sparse_table_range_min.sv -----
// Self-checking bench for the sparse-table range-minimum block.
// Requests are driven at the falling edge. Each accepted query is scored by a
// linear scan over a local copy of the value store. The scan returns the
// greatest position that holds the minimum, the same answer the sparse table
// gives. Responses are compared, in order, against the queue of predictions.
module tb_sparse_table_range_min;

   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_QUERY = 1'b1;
   localparam int   STORE_DEPTH = strm_pkg::DEF_MAX_ELEMENTS;
   localparam int   IDLE_LIMIT  = 60000;   // covers a full 1024-entry rebuild, many times over
   localparam int   SETTLE_CYCLES = 30;
   localparam int   RANDOM_ITEMS  = 1200;

   typedef struct {
      logic [strm_pkg::IDX_W-1:0] position;
      logic                       err;
   } range_answer_type;

   logic clock;
   logic reset;
   logic req_valid, req_ready, req_mode;
   logic [strm_pkg::IDX_W-1:0] req_write_index, req_range_start, req_range_end;
   logic signed [strm_pkg::VAL_W-1:0] req_write_value;
   logic rsp_valid, rsp_ready, rsp_range_error;
   logic [strm_pkg::IDX_W-1:0] rsp_min_position;
   logic csr_valid, csr_ready;
   logic [strm_pkg::SIZE_W-1:0] csr_size_in_use;

   // local copy of the block state
   logic signed [strm_pkg::VAL_W-1:0] shadow_values [STORE_DEPTH];
   logic [strm_pkg::SIZE_W-1:0]       shadow_size;
   range_answer_type                  pending_answers[$];

   int  error_count;
   int  items_sent;
   int  idle_cycles;
   int  stall_left;
   bit  sender_gaps;
   bit  receiver_stalls;

   sparse_table_range_min i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_write_index  (req_write_index),
      .req_write_value  (req_write_value),
      .req_range_start  (req_range_start),
      .req_range_end    (req_range_end),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_min_position (rsp_min_position),
      .rsp_range_error  (rsp_range_error),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_size_in_use  (csr_size_in_use)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // sizes above the store depth act as the full store
   function automatic int active_size();
      return (shadow_size > STORE_DEPTH) ? STORE_DEPTH : int'(shadow_size);
   endfunction

   function automatic range_answer_type scan_minimum(int first, int last);
      range_answer_type ans;
      int n;
      n = active_size();
      ans.position = '0;
      ans.err      = 1'b0;
      if (first > last || last >= n) begin
         ans.err = 1'b1;
      end else begin
         ans.position = strm_pkg::IDX_W'(first);
         // <= keeps moving right on ties: greatest position wins
         for (int i = first + 1; i <= last; i++) begin
            if (shadow_values[i] <= shadow_values[ans.position]) begin
               ans.position = strm_pkg::IDX_W'(i);
            end
         end
      end
      return ans;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // One request: hold until accepted, update the shadow, then maybe idle.
   task automatic send_request(logic mode, int index, int value, int first, int last);
      int gap;
      @(negedge clock);
      req_valid       <= 1'b1;
      req_mode        <= mode;
      req_write_index <= strm_pkg::IDX_W'(index);
      req_write_value <= strm_pkg::VAL_W'(value);
      req_range_start <= strm_pkg::IDX_W'(first);
      req_range_end   <= strm_pkg::IDX_W'(last);
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (mode == MODE_WRITE) begin
         if (index < active_size()) shadow_values[index] = strm_pkg::VAL_W'(value);
      end else begin
         pending_answers.push_back(scan_minimum(first, last));
      end
      gap = 0;
      if (sender_gaps && $urandom_range(0, 9) >= 6) begin
         gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      end
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic write_query(int first, int last);
      send_request(MODE_QUERY, $urandom_range(0, 1023), $urandom, first, last);
   endtask

   // Wait until all responses are back; the sender is idle meanwhile.
   task automatic drain_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // Size register is only written with the block idle.
   task automatic write_size(int size);
      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid       <= 1'b1;
      csr_size_in_use <= strm_pkg::SIZE_W'(size);
      do @(posedge clock); while (!csr_ready);
      shadow_size = strm_pkg::SIZE_W'(size);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Extremes of values and positions at the reset size.
   task automatic test_extremes();
      write_query(0, 1023);                        // all zero: ties resolve to 1023
      send_request(MODE_WRITE, 0, 32'h8000_0000, 0, 0);
      send_request(MODE_WRITE, 1023, 32'h7fff_ffff, 0, 0);
      write_query(0, 1023);
      write_query(1023, 1023);
      write_query(1, 1023);
      write_query(5, 4);                           // start beyond end
      send_request(MODE_WRITE, 512, -7, 0, 0);
      send_request(MODE_WRITE, 700, -7, 0, 0);     // tie with 512
      write_query(1, 1023);
      write_query(1, 600);
   endtask

   // Writes and queries around each size boundary, including zero and oversize.
   task automatic test_size_limits();
      write_size(10);
      send_request(MODE_WRITE, 10, -100, 0, 0);    // beyond size, dropped
      send_request(MODE_WRITE, 9, -50, 0, 0);
      write_query(0, 9);
      write_query(0, 10);                          // end beyond size
      write_size(0);
      send_request(MODE_WRITE, 0, -1000, 0, 0);
      write_query(0, 0);
      write_size(1);
      write_query(0, 0);
      write_size(2047);                            // behaves as 1024
      write_query(0, 1023);
      write_query(1022, 1023);
   endtask

   // Pause sending until the pipe is empty, then resume sending.
   task automatic test_drained_restart();
      write_size(16);
      for (int i = 0; i < 6; i++) send_request(MODE_WRITE, i, $urandom_range(0, 3), 0, 0);
      write_query(0, 15);
      write_query(2, 5);
      drain_responses();
      write_query(0, 5);
      write_query(3, 3);
   endtask

   task automatic random_item(int n, int write_pct);
      int value_pick, value, first, last;
      if ($urandom_range(0, 99) < write_pct) begin
         value_pick = $urandom_range(0, 9);
         if (value_pick < 4)      value = $urandom_range(0, 6) - 3;   // many ties
         else if (value_pick < 8) value = $urandom;
         else if (value_pick == 8) value = 32'h8000_0000;
         else                      value = 32'h7fff_ffff;
         send_request(MODE_WRITE,
                      (n > 0 && $urandom_range(0, 9) < 8) ? $urandom_range(0, n - 1)
                                                          : $urandom_range(0, 1023),
                      value, $urandom_range(0, 1023), $urandom_range(0, 1023));
      end else begin
         if (n > 0 && $urandom_range(0, 99) < 85) begin
            first = $urandom_range(0, n - 1);
            last  = $urandom_range(first, n - 1);
         end else begin
            first = $urandom_range(0, 1023);
            last  = $urandom_range(0, 1023);
         end
         send_request(MODE_QUERY, $urandom_range(0, 1023), $urandom, first, last);
      end
   endtask

   // Phases of random traffic, each at its own size; large sizes are rare and
   // carry few writes since every write forces a full rebuild.
   task automatic test_random_traffic();
      int size_pick, size, n;
      while (items_sent < RANDOM_ITEMS) begin
         size_pick = $urandom_range(0, 19);
         case (size_pick)
            0:       size = 0;
            1:       size = $urandom_range(1024, 2047);
            2:       size = $urandom_range(65, 1023);
            default: size = $urandom_range(1, 48);
         endcase
         write_size(size);
         n = active_size();
         sender_gaps     = ($urandom_range(0, 3) != 0);
         receiver_stalls = ($urandom_range(0, 3) != 0);
         for (int i = 0; i < 60; i++) random_item(n, (n > 64) ? 4 : 40);
      end
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
   endtask

   // Response side: random stalls, mostly short, some long.
   always @(negedge clock) begin
      if (!receiver_stalls) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         case ($urandom_range(0, 9))
            0, 1:    stall_left <= $urandom_range(1, 3);
            2:       stall_left <= $urandom_range(10, 50);
            default: stall_left <= 0;
         endcase
      end
   end

   // Scoreboard: each response against the oldest prediction.
   always @(posedge clock) begin
      range_answer_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_answers.size() == 0) begin
            report_mismatch("response with no query pending", rsp_min_position, -1);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_range_error !== want.err)
               report_mismatch("range_error", rsp_range_error, want.err);
            if (rsp_min_position !== want.position)
               report_mismatch("min_position", rsp_min_position, want.position);
         end
      end
   end

   // Watchdog: too long without any handshake means the block is stuck.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
         $display("CHECKS FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_mode        = MODE_WRITE;
      req_write_index = '0;
      req_write_value = '0;
      req_range_start = '0;
      req_range_end   = '0;
      rsp_ready       = 1'b0;
      csr_valid       = 1'b0;
      csr_size_in_use = strm_pkg::SIZE_RESET;
      error_count     = 0;
      items_sent      = 0;
      idle_cycles     = 0;
      stall_left      = 0;
      sender_gaps     = 1'b1;
      receiver_stalls = 1'b1;
      shadow_size     = strm_pkg::SIZE_RESET;
      for (int i = 0; i < STORE_DEPTH; i++) shadow_values[i] = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_extremes();
      test_size_limits();
      test_drained_restart();
      items_sent = 0;
      test_random_traffic();

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
